// File: design/signed_int_to_decimal_ascii_unit_macros.svh
// Assertion macros shared by the converter modules.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SITDA_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define SITDA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SITDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SITDA_ASSERT(lbl, cond)
`define SITDA_ASSERT_IMP(lbl, ante, cons)
`define SITDA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/sitda_pkg.sv
package sitda_pkg;

	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [5:0] CHAR_ZERO  = 6'd48;

	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic bits_done;
		logic one_left;
		logic top_zero;
		logic neg;
	} sts_t;

endpackage

// File: design/sitda_ctrl.sv
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output sitda_pkg::cmd_t   cmd,
	input  sitda_pkg::sts_t   sts
);
	import sitda_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (sts.bits_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (sts.top_zero && !sts.one_left) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.emit_sign = sts.neg;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				cmd.shift      = 1'b1;
				if (sts.one_left) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SITDA_ASSERT_IMP(a_idle_quiet, !busy, !(cmd.dabble || cmd.emit_digit || cmd.emit_sign))
	`SITDA_ASSERT_NEXT(a_start_conv, start && !busy, state_q == ST_CONV)
	`SITDA_ASSERT_NEXT(a_last_idle, cmd.emit_digit && sts.one_left, !busy)

endmodule

// File: design/sitda_dp.sv
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitda_dp #(
	parameter int VALUE_WIDTH = 32,
	parameter int DIGITS      = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sitda_pkg::cmd_t        cmd,
	output sitda_pkg::sts_t        sts,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   strobe,
	output logic [5:0]             char_code,
	output logic                   last
);
	import sitda_pkg::*;

	localparam int BW   = $clog2(VALUE_WIDTH + 1);
	localparam int DW   = $clog2(DIGITS + 1);
	localparam int BCDW = 4 * DIGITS;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCDW-1:0]        bcd_q;
	logic [BCDW-1:0]        bcd_adj;
	logic                   neg_q;
	logic [BW-1:0]          bit_cnt_q;
	logic [DW-1:0]          dig_cnt_q;
	logic                   strobe_q;
	logic [5:0]             char_q;
	logic                   last_q;
	logic [3:0]             top_digit;

	assign top_digit = bcd_q[BCDW-1 -: 4];

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
	end

	assign sts.bits_done = (bit_cnt_q == BW'(1));
	assign sts.one_left  = (dig_cnt_q == DW'(1));
	assign sts.top_zero  = (top_digit == 4'd0);
	assign sts.neg       = neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_sign | cmd.emit_digit;
			if (cmd.load) begin
				bit_cnt_q <= BW'(VALUE_WIDTH);
				dig_cnt_q <= DW'(DIGITS);
			end else if (cmd.dabble) begin
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end else if (cmd.shift) begin
				dig_cnt_q <= dig_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_WIDTH-1];
			mag_q <= value[VALUE_WIDTH-1]
				? ((~value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;
			bcd_q <= '0;
		end else if (cmd.dabble) begin
			bcd_q <= {bcd_adj[BCDW-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BCDW-5:0], 4'd0};
		end
		char_q <= cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO | {2'b00, top_digit});
		last_q <= cmd.emit_digit & sts.one_left;
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

	`SITDA_ASSERT_IMP(a_minus_not_last, strobe_q && char_q == CHAR_MINUS, !last_q)
	`SITDA_ASSERT_IMP(a_char_legal, strobe_q,
		char_q == CHAR_MINUS || (char_q[5:4] == 2'b11 && char_q[3:0] <= 4'd9))
	`SITDA_ASSERT_IMP(a_digit_bcd, cmd.emit_digit, top_digit <= 4'd9)

endmodule

// File: design/signed_int_to_decimal_ascii_unit.sv
// Converts one signed VALUE_WIDTH-bit integer to its decimal text, one ASCII
// character per strobe, most significant first: a minus sign for negative
// values, then the digits without leading zeros; last marks the final
// character. The receiver cannot stall: each character is on char_code for
// exactly one cycle and must be taken then. An item goes through the accept
// step, one double-dabble shift per value bit, one skip step per leading zero
// dropped, a step to leave the skip state (emitting the sign if any) and one
// step per digit; a new value is accepted only once busy is low again. DIGITS
// is the digit count of 2^(VALUE_WIDTH-1). The last character is on the ports
// in the first cycle that busy is low.
module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          busy,
	output logic                          strobe,
	output logic [5:0]                    char_code,
	output logic                          last
);
	import sitda_pkg::*;

	localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

	cmd_t cmd;
	sts_t sts;

	sitda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	sitda_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGITS      (DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last)
	);

endmodule
